// ===== rtl/core/hstw_pkg.sv =====
// ----------------------------------------------------------------------------
// hstw_pkg
// Types and constants shared by the two-wire humidity sensor master.
// ----------------------------------------------------------------------------
package hstw_pkg;

  typedef struct packed {
    logic [2:0] action;
    logic       data_line_in;
  } in_item_t;

  typedef struct packed {
    logic        clock_line;
    logic        data_drive_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] result_value;
    logic [1:0]  status_code;
  } out_item_t;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_START   = 4'd1;
  localparam logic [3:0] PH_WR_LO   = 4'd2;
  localparam logic [3:0] PH_WR_HI   = 4'd3;
  localparam logic [3:0] PH_WACK_LO = 4'd4;
  localparam logic [3:0] PH_WACK_HI = 4'd5;
  localparam logic [3:0] PH_POLL    = 4'd6;
  localparam logic [3:0] PH_RD_LO   = 4'd7;
  localparam logic [3:0] PH_RD_HI   = 4'd8;
  localparam logic [3:0] PH_RACK_LO = 4'd9;
  localparam logic [3:0] PH_RACK_HI = 4'd10;
  localparam logic [3:0] PH_RST_HI  = 4'd11;
  localparam logic [3:0] PH_RST_LO  = 4'd12;

  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_TEMP    = 3'd1;
  localparam logic [2:0] CMD_HUMID   = 3'd2;
  localparam logic [2:0] CMD_STATUS  = 3'd3;
  localparam logic [2:0] CMD_SRESET  = 3'd4;
  localparam logic [2:0] CMD_TRAIL   = 3'd5;
  localparam logic [2:0] CMD_TRAIL_R = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ACK  = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_CRC     = 2'd3;

  localparam logic [7:0] CRC_POLY   = 8'h31;
  localparam logic [19:0] TIMEOUT_RESET = 20'd250000;

  function automatic logic [7:0] cmd_byte(input logic [2:0] c);
    case (c)
      CMD_TEMP:   cmd_byte = 8'h03;
      CMD_HUMID:  cmd_byte = 8'h05;
      CMD_STATUS: cmd_byte = 8'h07;
      default:    cmd_byte = 8'h1E;
    endcase
  endfunction

  function automatic logic [7:0] crc_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] a;
    a = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      a = a[7] ? ((a << 1) ^ CRC_POLY) : (a << 1);
    end
    crc_byte = a;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    for (int i = 0; i < 8; i++) begin
      rev8[i] = v[7-i];
    end
  endfunction

endpackage

// ===== rtl/core/hstw_front.sv =====
// ----------------------------------------------------------------------------
// hstw_front
// Accepts slot items, classifies the action and queues them for the sequencer.
// ----------------------------------------------------------------------------
module hstw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hstw_pkg::in_item_t in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output hstw_pkg::in_item_t q_data
);
  hstw_pkg::in_item_t buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  hstw_pkg::in_item_t cls;

  always_comb begin
    cls = in_data;
    if (in_data.action > hstw_pkg::CMD_SRESET) cls.action = hstw_pkg::CMD_NONE;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) buf_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((in_valid && in_ready) ? 1 : 0) - 2'((q_valid && q_ready) ? 1 : 0);
    end
  end
endmodule

// ===== rtl/core/hstw_seq.sv =====
// ----------------------------------------------------------------------------
// hstw_seq
// Slot sequencer: one queued item per cycle unless stalled; registered result.
// ----------------------------------------------------------------------------
module hstw_seq #(
  parameter int WAIT_COUNTER_BITS = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [19:0]         timeout_limit,
  input  logic                q_valid,
  output logic                q_ready,
  input  hstw_pkg::in_item_t  q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hstw_pkg::out_item_t out_data
);
  localparam logic [WAIT_COUNTER_BITS-1:0] WMASK = '1;
  localparam int CW = (WAIT_COUNTER_BITS + 1 > 20) ? WAIT_COUNTER_BITS + 1 : 20;

  logic [3:0] ph_r, ph_nxt;
  logic [2:0] cmd_r, cmd_nxt;
  logic [3:0] bc_r, bc_nxt;
  logic [7:0] sh_r, sh_nxt, hi_r, hi_nxt, crc_r, crc_nxt;
  logic [WAIT_COUNTER_BITS-1:0] wc_r, wc_nxt;
  logic [1:0] perr_r, perr_nxt;
  logic       ov_r;
  hstw_pkg::out_item_t od_r, o;

  logic [3:0] ph;
  logic [3:0] bc, k;
  logic [2:0] pos;
  logic       din, step, wbit, second, ack;
  logic [WAIT_COUNTER_BITS:0] n;
  logic [CW-1:0] n_cmp, tl_cmp;
  logic [7:0] wbyte;

  assign q_ready   = !ov_r || out_ready;
  assign step      = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign din       = q_data.data_line_in;

  always_comb begin
    ph = ph_r; bc = bc_r;
    ph_nxt = ph_r; cmd_nxt = cmd_r; bc_nxt = bc_r; sh_nxt = sh_r; hi_nxt = hi_r;
    crc_nxt = crc_r; wc_nxt = wc_r; perr_nxt = perr_r;
    o = '0;
    k = 4'd0; pos = 3'd0; wbit = 1'b0; second = 1'b0; ack = 1'b0; n = '0;
    n_cmp = '0; tl_cmp = '0; wbyte = 8'd0;
    if (ph_r == hstw_pkg::PH_IDLE && q_data.action != hstw_pkg::CMD_NONE) begin
      cmd_nxt = q_data.action; perr_nxt = 2'd0; ph = hstw_pkg::PH_START;
      bc = 4'd0; bc_nxt = 4'd0;
    end
    o.busy_res = (ph != hstw_pkg::PH_IDLE);
    ph_nxt = ph;
    case (ph)
      hstw_pkg::PH_START: begin
        k = (bc < 4'd6) ? bc : 4'd5;
        case (k)
          4'd0: begin o.clock_line = 1'b0; o.data_drive_low = 1'b0; end
          4'd1: begin o.clock_line = 1'b1; o.data_drive_low = 1'b0; end
          4'd2: begin o.clock_line = 1'b1; o.data_drive_low = 1'b1; end
          4'd3: begin o.clock_line = 1'b0; o.data_drive_low = 1'b1; end
          4'd4: begin o.clock_line = 1'b1; o.data_drive_low = 1'b1; end
          default: begin o.clock_line = 1'b1; o.data_drive_low = 1'b0; end
        endcase
        if (k == 4'd5) begin
          if (cmd_nxt == hstw_pkg::CMD_TRAIL_R) begin
            o.done_res = 1'b1; o.result_value = {hi_r, sh_r}; ph_nxt = hstw_pkg::PH_IDLE;
          end else if (perr_nxt != hstw_pkg::ST_OK) begin
            o.done_res = 1'b1; o.status_code = perr_nxt; ph_nxt = hstw_pkg::PH_IDLE;
          end else begin
            ph_nxt = hstw_pkg::PH_WR_LO;
          end
          bc_nxt = 4'd0;
        end else begin
          bc_nxt = k + 4'd1;
        end
      end
      hstw_pkg::PH_WR_LO, hstw_pkg::PH_WR_HI: begin
        pos = bc[2:0];
        wbyte = hstw_pkg::cmd_byte(cmd_nxt);
        wbit = wbyte[3'd7 - pos];
        o.data_drive_low = !wbit;
        if (ph == hstw_pkg::PH_WR_LO) ph_nxt = hstw_pkg::PH_WR_HI;
        else begin
          o.clock_line = 1'b1;
          if (pos == 3'd7) begin ph_nxt = hstw_pkg::PH_WACK_LO; bc_nxt = 4'd0; end
          else begin ph_nxt = hstw_pkg::PH_WR_LO; bc_nxt = {1'b0, pos} + 4'd1; end
        end
      end
      hstw_pkg::PH_WACK_LO: ph_nxt = hstw_pkg::PH_WACK_HI;
      hstw_pkg::PH_WACK_HI: begin
        o.clock_line = 1'b1;
        if (din) begin
          ph_nxt = hstw_pkg::PH_RST_HI; bc_nxt = 4'd0;
          if (cmd_r == hstw_pkg::CMD_TRAIL) begin
            cmd_nxt = hstw_pkg::CMD_TRAIL_R; perr_nxt = hstw_pkg::ST_OK;
          end else perr_nxt = hstw_pkg::ST_NO_ACK;
        end else if (cmd_r == hstw_pkg::CMD_TEMP || cmd_r == hstw_pkg::CMD_HUMID) begin
          ph_nxt = hstw_pkg::PH_POLL; wc_nxt = '0;
        end else if (cmd_r == hstw_pkg::CMD_STATUS) begin
          ph_nxt = hstw_pkg::PH_RD_LO; bc_nxt = 4'd0;
          crc_nxt = hstw_pkg::crc_byte(8'd0, 8'h07);
        end else begin
          o.done_res = 1'b1;
          if (cmd_r == hstw_pkg::CMD_TRAIL) o.result_value = {hi_r, sh_r};
          ph_nxt = hstw_pkg::PH_IDLE;
        end
      end
      hstw_pkg::PH_POLL: begin
        if (!din) begin ph_nxt = hstw_pkg::PH_RD_LO; bc_nxt = 4'd0; end
        else begin
          n = {1'b0, wc_r} + 1'b1;
          n_cmp = CW'(n);
          tl_cmp = CW'(timeout_limit);
          if (n_cmp >= tl_cmp || n >= {1'b0, WMASK}) begin
            ph_nxt = hstw_pkg::PH_RST_HI; bc_nxt = 4'd0; perr_nxt = hstw_pkg::ST_TIMEOUT;
          end else wc_nxt = n[WAIT_COUNTER_BITS-1:0];
        end
      end
      hstw_pkg::PH_RD_LO: ph_nxt = hstw_pkg::PH_RD_HI;
      hstw_pkg::PH_RD_HI: begin
        o.clock_line = 1'b1;
        sh_nxt = {sh_r[6:0], din};
        if (bc[2:0] == 3'd7) ph_nxt = hstw_pkg::PH_RACK_LO;
        else begin ph_nxt = hstw_pkg::PH_RD_LO; bc_nxt = bc + 4'd1; end
      end
      hstw_pkg::PH_RACK_LO, hstw_pkg::PH_RACK_HI: begin
        second = bc[3];
        ack = !(cmd_r == hstw_pkg::CMD_STATUS && second);
        o.data_drive_low = ack;
        if (ph == hstw_pkg::PH_RACK_LO) ph_nxt = hstw_pkg::PH_RACK_HI;
        else begin
          o.clock_line = 1'b1;
          if (!second) begin
            hi_nxt = sh_r;
            if (cmd_r == hstw_pkg::CMD_STATUS) crc_nxt = hstw_pkg::crc_byte(crc_r, sh_r);
            bc_nxt = 4'd8; ph_nxt = hstw_pkg::PH_RD_LO;
          end else if (cmd_r == hstw_pkg::CMD_STATUS) begin
            if (crc_r == hstw_pkg::rev8(sh_r)) begin
              o.done_res = 1'b1; o.result_value = {8'd0, hi_r}; ph_nxt = hstw_pkg::PH_IDLE;
            end else begin
              ph_nxt = hstw_pkg::PH_RST_HI; bc_nxt = 4'd0; perr_nxt = hstw_pkg::ST_CRC;
            end
          end else begin
            cmd_nxt = hstw_pkg::CMD_TRAIL; ph_nxt = hstw_pkg::PH_START; bc_nxt = 4'd0;
          end
        end
      end
      hstw_pkg::PH_RST_HI: begin o.clock_line = 1'b1; ph_nxt = hstw_pkg::PH_RST_LO; end
      hstw_pkg::PH_RST_LO: begin
        if (bc >= 4'd8) begin ph_nxt = hstw_pkg::PH_START; bc_nxt = 4'd0; end
        else begin ph_nxt = hstw_pkg::PH_RST_HI; bc_nxt = bc + 4'd1; end
      end
      default: begin ph_nxt = hstw_pkg::PH_IDLE; o.busy_res = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (step) od_r <= o;
    if (!rst_n) begin
      ph_r <= hstw_pkg::PH_IDLE; cmd_r <= 3'd0; bc_r <= 4'd0; sh_r <= 8'd0;
      hi_r <= 8'd0; wc_r <= '0; crc_r <= 8'd0; perr_r <= 2'd0; ov_r <= 1'b0;
    end else begin
      if (step) begin
        ph_r <= ph_nxt; cmd_r <= cmd_nxt; bc_r <= bc_nxt; sh_r <= sh_nxt;
        hi_r <= hi_nxt; wc_r <= wc_nxt; crc_r <= crc_nxt; perr_r <= perr_nxt;
        ov_r <= 1'b1;
      end else if (out_ready) ov_r <= 1'b0;
    end
  end
endmodule

// ===== rtl/core/humidity_sensor_two_wire_master.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_two_wire_master
// Slot-level master for a two-wire humidity/temperature sensor.
// ----------------------------------------------------------------------------
// Path: an accepted slot item passes the queue, then the output reg, before its result appears.
// Throughput: one item per cycle while out_ready does not stall the output; the sequencer advances one slot per item.
// Reset: synchronous active-low rst_n; sequencer idle, queue empty, timeout 250000.
module humidity_sensor_two_wire_master #(
  parameter int WAIT_COUNTER_BITS = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hstw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hstw_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [19:0]         cfg_wdata
);
  logic [19:0] tl_r;
  logic q_valid, q_ready;
  hstw_pkg::in_item_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) tl_r <= hstw_pkg::TIMEOUT_RESET;
    else if (cfg_we) tl_r <= cfg_wdata;
  end

  hstw_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  hstw_seq #(.WAIT_COUNTER_BITS(WAIT_COUNTER_BITS)) u_seq (
    .clk, .rst_n, .timeout_limit(tl_r), .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );
endmodule

// ===== rtl/core/hstw_checker.sv =====
// ----------------------------------------------------------------------------
// hstw_checker
// Port-level checks for the two-wire sensor master.
// ----------------------------------------------------------------------------
module hstw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input hstw_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> out_data.busy_res) else $error("done w/o busy");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |-> !out_data.clock_line && !out_data.data_drive_low)
    else $error("idle drive");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |-> out_data.result_value == 16'd0 &&
    out_data.status_code == 2'd0) else $error("value w/o done");
endmodule

bind humidity_sensor_two_wire_master hstw_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_data
);
